### rtl/channel_rate_gate_macros.svh
// assertion macros for the rate gate rtl
`ifndef CHANNEL_RATE_GATE_MACROS_SVH
`define CHANNEL_RATE_GATE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CRG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define CRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/crg_pkg.sv
// shared types and constants of the channel rate gate
`default_nettype none

package crg_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int SLOT_W    = 4;
   localparam int KEY_W     = 32;
   localparam int TIME_W    = 64;
   localparam int BYTES_W   = 31;
   localparam int MODE_W    = 2;
   localparam int IVL_W     = 32;
   localparam int CNT_W     = 32;

   localparam logic CMD_LOAD = 1'b1;

   localparam logic [MODE_W-1:0] MODE_ALWAYS    = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_ON_DEMAND = MODE_W'(1);

   typedef struct packed {
      logic                     cmd;
      logic [KEY_W-1:0]         channel_key;
      logic signed [TIME_W-1:0] time_us;
      logic [BYTES_W-1:0]       msg_size;
      logic [SLOT_W-1:0]        slot;
      logic [MODE_W-1:0]        mode;
      logic [IVL_W-1:0]         interval_us;
      logic                     to_base;
   } req_type;

   typedef struct packed {
      logic              forward;
      logic              matched;
      logic              dir_out;
      logic              on_demand_out;
      logic [SLOT_W-1:0] slot_out;
      logic [CNT_W-1:0]  msg_total;
      logic [CNT_W-1:0]  byte_total;
   } rsp_type;

   // one table entry as held in the slot memory
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IVL_W-1:0]  interval;
      logic              dir;
      logic [TIME_W-1:0] last_send;
      logic [CNT_W-1:0]  msg_count;
      logic [CNT_W-1:0]  byte_count;
   } entry_type;

   typedef struct packed {
      logic      forward;
      logic      demand_fwd;
      entry_type entry;
   } upd_type;

endpackage

`default_nettype wire

### rtl/crg_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module crg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/crg_key_match.sv
// key registers with valid bits, parallel compare and first-hit encoder
`default_nettype none

module crg_key_match #(
   parameter int SLOTS = 16,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load_en,
   input  wire logic [IDX_W-1:0]         load_idx,
   input  wire logic [crg_pkg::KEY_W-1:0] load_key,
   input  wire logic                     cmp_en,
   input  wire logic [crg_pkg::KEY_W-1:0] cmp_key,
   output logic                          hit_any,
   output logic      [IDX_W-1:0]         hit_idx
);

   import crg_pkg::*;

   logic [SLOTS-1:0] valid_ff;
   logic [KEY_W-1:0] key_ff [SLOTS];
   logic [SLOTS-1:0] hit_ff;
   logic [SLOTS-1:0] hit_in;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         hit_in[i] = valid_ff[i] && (key_ff[i] == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (load_en) begin
         valid_ff[load_idx] <= 1'b1;
      end
      if (load_en) begin
         key_ff[load_idx] <= load_key;
      end
      if (cmp_en) begin
         hit_ff <= hit_in;
      end
   end

   // lowest slot wins
   always_comb begin
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any = |hit_ff;

endmodule

`default_nettype wire

### rtl/crg_update.sv
// forwarding decision and counter update for one table entry
`default_nettype none

module crg_update (
   input  wire crg_pkg::entry_type          entry,
   input  wire logic [crg_pkg::TIME_W-1:0]  time_us,
   input  wire logic [crg_pkg::BYTES_W-1:0] msg_size,
   output crg_pkg::upd_type                 upd
);

   import crg_pkg::*;

   logic [TIME_W:0] gap;
   logic            gap_over;

   // exact signed difference, one extra bit so it never wraps
   assign gap = {time_us[TIME_W-1], time_us} - {entry.last_send[TIME_W-1], entry.last_send};
   assign gap_over = !gap[TIME_W] && (gap[TIME_W-1:0] > TIME_W'(entry.interval));

   always_comb begin
      upd.entry      = entry;
      upd.forward    = 1'b0;
      upd.demand_fwd = 1'b0;
      case (entry.mode)
         MODE_ALWAYS: begin
            upd.forward = 1'b1;
         end
         MODE_ON_DEMAND: begin
            upd.forward    = 1'b1;
            upd.demand_fwd = 1'b1;
         end
         default: begin
            // rate limited, both remaining codes
            upd.forward = gap_over;
            if (gap_over) begin
               upd.entry.last_send = time_us;
            end
         end
      endcase
      if (upd.forward) begin
         upd.entry.msg_count  = entry.msg_count + CNT_W'(1);
         upd.entry.byte_count = entry.byte_count + CNT_W'(msg_size);
      end
   end

endmodule

`default_nettype wire

### rtl/channel_rate_gate.sv
// channel rate gate top level: sequencer, slot memory and result register
// a message runs through the match, read and modify steps (match and read only when no key
//   matches), a load through the load step, before its result is registered; a new beat is
//   taken only once the previous item has left these steps
// reset clears the slot valid bits at once; no clearing pass, entries are written by loads
// a finished result sits in the output register while the next beat is taken
`default_nettype none
`include "channel_rate_gate_macros.svh"

module channel_rate_gate #(
   parameter int SLOTS = crg_pkg::SLOTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire crg_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output crg_pkg::rsp_type      rsp_data
);

   import crg_pkg::*;

   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MATCH,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // result built this cycle, and whether there is one
   rsp_type          new_res;
   logic             have_res;
   logic             out_free;

   // load path
   logic [EXT_W-1:0] slot_ext;
   logic [IDX_W-1:0] load_idx;
   logic             load_ok;
   entry_type        load_entry;

   // match and memory
   logic             hit_any;
   logic [IDX_W-1:0] hit_idx;
   logic [EXT_W-1:0] idx_ext;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rbits;
   entry_type        ram_rdata;
   upd_type          upd;

   // slot decode, loads beyond the table are dropped
   assign slot_ext = EXT_W'(req_ff.slot);
   assign load_idx = slot_ext[IDX_W-1:0];
   assign load_ok  = (32'(req_ff.slot) < 32'(SLOTS));
   assign idx_ext  = EXT_W'(idx_ff);

   // a load starts the slot afresh: send time and counters zero
   always_comb begin
      load_entry          = '0;
      load_entry.mode     = req_ff.mode;
      load_entry.interval = req_ff.interval_us;
      load_entry.dir      = req_ff.to_base;
   end

   crg_key_match #(
      .SLOTS (SLOTS)
   ) u_match (
      .clock    (clock),
      .reset    (reset),
      .load_en  ((state_ff == ST_LOAD) && load_ok),
      .load_idx (load_idx),
      .load_key (req_ff.channel_key),
      .cmp_en   (state_ff == ST_MATCH),
      .cmp_key  (req_ff.channel_key),
      .hit_any  (hit_any),
      .hit_idx  (hit_idx)
   );

   // write on load, or on write-back of a forwarded message
   assign ram_we    = ((state_ff == ST_LOAD) && load_ok) ||
                      ((state_ff == ST_MODIFY) && upd.forward);
   assign ram_waddr = (state_ff == ST_LOAD) ? load_idx : idx_ff;
   assign ram_wdata = (state_ff == ST_LOAD) ? ENTRY_W'(load_entry) : ENTRY_W'(upd.entry);

   crg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (state_ff == ST_READ),
      .raddr (hit_idx),
      .rdata (ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   crg_update u_update (
      .entry    (ram_rdata),
      .time_us  (req_ff.time_us),
      .msg_size (req_ff.msg_size),
      .upd      (upd)
   );

   // output register can take a result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      new_res      = '0;
      have_res     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = (req_data.cmd == CMD_LOAD) ? ST_LOAD : ST_MATCH;
            end
         end
         ST_LOAD: begin
            new_res.slot_out = req_ff.slot;
            have_res         = 1'b1;
         end
         ST_MATCH: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            // entry read issued here, data back next cycle
            idx_in = hit_idx;
            if (hit_any) begin
               state_in = ST_MODIFY;
            end else begin
               have_res = 1'b1;
            end
         end
         ST_MODIFY: begin
            new_res.forward       = upd.forward;
            new_res.matched       = 1'b1;
            new_res.dir_out       = upd.forward && ram_rdata.dir;
            new_res.on_demand_out = upd.demand_fwd;
            new_res.slot_out      = idx_ext[SLOT_W-1:0];
            new_res.msg_total     = upd.entry.msg_count;
            new_res.byte_total    = upd.entry.byte_count;
            have_res              = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // finished result goes straight out, or parks until the port drains
      if (have_res) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = new_res;
            state_in     = ST_IDLE;
         end else begin
            res_in   = new_res;
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // one item in flight at a time
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CRG_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall,
      "beat taken while an item is still in flight")
   `CRG_ASSERT_NOW(a_unmatched_zero, clock, reset, rsp_valid && !rsp_data.matched,
      !rsp_data.forward && !rsp_data.dir_out && !rsp_data.on_demand_out &&
      (rsp_data.msg_total == '0) && (rsp_data.byte_total == '0),
      "unmatched or load result carries nonzero fields")
   `CRG_ASSERT_NOW(a_flags_need_match, clock, reset, rsp_valid && (rsp_data.on_demand_out || rsp_data.dir_out),
      rsp_data.forward && rsp_data.matched,
      "on-demand or direction flag without a forwarded match")
   `CRG_ASSERT_NOW(a_result_from_item, clock, reset, $rose(rsp_valid), $past(req_stall),
      "result appeared with no item in flight")

endmodule

`default_nettype wire

### dv/channel_rate_gate_checker.sv
// scoreboard for the channel rate gate: slot table model, expected results and field compares
`timescale 1ns / 1ps

module channel_rate_gate_checker
   import crg_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      loads_seen,
   output int      forwards_seen,
   output int      holds_seen,
   output int      misses_seen
);

   localparam int PRINT_CAP = 40;

   logic               tbl_valid [SLOTS];
   logic [KEY_W-1:0]   tbl_key   [SLOTS];
   logic [MODE_W-1:0]  tbl_mode  [SLOTS];
   logic [IVL_W-1:0]   tbl_ivl   [SLOTS];
   logic               tbl_dir   [SLOTS];
   logic [TIME_W-1:0]  tbl_last  [SLOTS];
   logic [CNT_W-1:0]   tbl_msgs  [SLOTS];
   logic [CNT_W-1:0]   tbl_bytes [SLOTS];

   // newest prediction at the front, oldest at the back
   rsp_type gate_results [$];

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP)
         $display("%0t: mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
   endtask

   // table update and result of one accepted beat
   function automatic rsp_type gate_beat(input req_type r);
      rsp_type res;
      int h;
      logic [TIME_W:0] gap;
      logic pass;
      logic od;
      res = '0;
      h = -1;
      od = 1'b0;
      if (r.cmd == CMD_LOAD) begin
         if (r.slot < SLOTS) begin
            tbl_valid[r.slot] = 1'b1;
            tbl_key[r.slot]   = r.channel_key;
            tbl_mode[r.slot]  = r.mode;
            tbl_ivl[r.slot]   = r.interval_us;
            tbl_dir[r.slot]   = r.to_base;
            tbl_last[r.slot]  = '0;
            tbl_msgs[r.slot]  = '0;
            tbl_bytes[r.slot] = '0;
         end
         res.slot_out = r.slot;
         loads_seen++;
         return res;
      end
      // lowest numbered valid slot wins
      for (int i = SLOTS - 1; i >= 0; i--)
         if (tbl_valid[i] && tbl_key[i] == r.channel_key)
            h = i;
      if (h < 0) begin
         misses_seen++;
         return res;
      end
      case (tbl_mode[h])
         MODE_ALWAYS:    pass = 1'b1;
         MODE_ON_DEMAND: begin
            pass = 1'b1;
            od   = 1'b1;
         end
         default: begin
            // exact signed difference, one bit wider so it cannot wrap
            gap  = {r.time_us[TIME_W-1], r.time_us} - {tbl_last[h][TIME_W-1], tbl_last[h]};
            pass = !gap[TIME_W] && (gap[TIME_W-1:0] > {{(TIME_W-IVL_W){1'b0}}, tbl_ivl[h]});
            if (pass)
               tbl_last[h] = r.time_us;
         end
      endcase
      if (pass) begin
         tbl_msgs[h]       = tbl_msgs[h] + 1'b1;
         tbl_bytes[h]      = tbl_bytes[h] + {1'b0, r.msg_size};
         res.forward       = 1'b1;
         res.dir_out       = tbl_dir[h];
         res.on_demand_out = od;
         forwards_seen++;
      end else begin
         holds_seen++;
      end
      res.matched    = 1'b1;
      res.slot_out   = SLOT_W'(h);
      res.msg_total  = tbl_msgs[h];
      res.byte_total = tbl_bytes[h];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
         gate_results.delete();
         fail_count    = 0;
         loads_seen    = 0;
         forwards_seen = 0;
         holds_seen    = 0;
         misses_seen   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (gate_results.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing outstanding: %h", rsp_data));
            end else begin
               want = gate_results.pop_back();
               check_field("forward", rsp_data.forward, want.forward);
               check_field("matched", rsp_data.matched, want.matched);
               check_field("dir_out", rsp_data.dir_out, want.dir_out);
               check_field("on_demand_out", rsp_data.on_demand_out, want.on_demand_out);
               check_field("slot_out", rsp_data.slot_out, want.slot_out);
               check_field("msg_total", rsp_data.msg_total, want.msg_total);
               check_field("byte_total", rsp_data.byte_total, want.byte_total);
            end
         end
         if (req_valid && !req_stall)
            gate_results.push_front(gate_beat(req_data));
      end
      pending = gate_results.size();
   end

endmodule

### dv/channel_rate_gate_tb.sv
// top of the channel rate gate testbench: clock, reset, stimulus, idling and verdict
`timescale 1ns / 1ps

module channel_rate_gate_tb;
   import crg_pkg::*;

   // codes the package leaves unnamed
   localparam logic              CMD_MESSAGE = ~CMD_LOAD;
   localparam logic [MODE_W-1:0] MODE_RATE   = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_SPARE  = MODE_W'(3);   // behaves as rate limited

   localparam int KEY_POOL     = 12;
   localparam int PHASE_BEATS  = 360;    // three phases, about 1100 beats with the directed part
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off to fill the block
   localparam int QUIET_LIMIT  = 3000;   // cycles without any accepted beat or result before giving up
   localparam int DRAIN_CYCLES = 12;     // quiet stretch after the last result comes home

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // idle percentages per side, changed between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long hold-off request, handled by the receiver process
   logic hold_go   = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;

   int fail_count, pending, loads_seen, forwards_seen, holds_seen, misses_seen;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   channel_rate_gate dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   channel_rate_gate_checker gate_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .loads_seen    (loads_seen),
      .forwards_seen (forwards_seen),
      .holds_seen    (holds_seen),
      .misses_seen   (misses_seen)
   );

   // receiver: random stall, or one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // load beat: fields a load does not use get random content
   function automatic req_type load_beat(input logic [SLOT_W-1:0] slot,
                                         input logic [KEY_W-1:0] key,
                                         input logic [MODE_W-1:0] mode,
                                         input logic [IVL_W-1:0] ivl,
                                         input logic dir);
      req_type b;
      b.cmd         = CMD_LOAD;
      b.channel_key = key;
      b.time_us     = {$urandom, $urandom};
      b.msg_size    = BYTES_W'($urandom);
      b.slot        = slot;
      b.mode        = mode;
      b.interval_us = ivl;
      b.to_base     = dir;
      return b;
   endfunction

   // message beat: slot, mode, interval and direction are don't-care noise
   function automatic req_type msg_beat(input logic [KEY_W-1:0] key,
                                        input logic signed [TIME_W-1:0] stamp,
                                        input logic [BYTES_W-1:0] bytes);
      req_type b;
      b.cmd         = CMD_MESSAGE;
      b.channel_key = key;
      b.time_us     = stamp;
      b.msg_size    = bytes;
      b.slot        = SLOT_W'($urandom);
      b.mode        = MODE_W'($urandom);
      b.interval_us = $urandom;
      b.to_base     = $urandom_range(1);
      return b;
   endfunction

   // offer one beat after a random gap and wait for it to be taken;
   // valid stays high straight into the next beat when no gap is drawn
   task automatic send_beat(input req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
   endtask

   // watchdog: ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d quiet cycles, %0d results outstanding", quiet, pending);
      $display("channel_rate_gate verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned key_pool [KEY_POOL];
      logic signed [TIME_W-1:0] now_us;
      logic [KEY_W-1:0] key;
      logic [IVL_W-1:0] ivl;
      logic [BYTES_W-1:0] bytes;
      int pick;

      // key 0 and all ones are in the pool so random beats revisit the extremes
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < KEY_POOL; i++)
         key_pool[i] = $urandom;
      now_us = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty table: nothing matches
      send_beat(msg_beat(32'h0000_0000, 64'sd0, 31'd1));
      send_beat(load_beat(4'd0, 32'h0000_0000, MODE_ALWAYS, 32'd0, 1'b1));
      send_beat(load_beat(4'd15, 32'hFFFF_FFFF, MODE_ON_DEMAND, 32'hFFFF_FFFF, 1'b0));
      send_beat(load_beat(4'd5, 32'h0000_1234, MODE_RATE, 32'd10, 1'b1));
      // same key in a higher slot: the lower slot must win
      send_beat(load_beat(4'd6, 32'h0000_1234, MODE_ALWAYS, 32'd0, 1'b0));
      send_beat(load_beat(4'd7, 32'h5555_5555, MODE_SPARE, 32'd0, 1'b1));
      send_beat(load_beat(4'd8, 32'hA5A5_A5A5, MODE_RATE, 32'hFFFF_FFFF, 1'b1));
      // biggest messages: the byte count wraps on the third
      send_beat(msg_beat(32'h0000_0000, 64'sd0, 31'h7FFF_FFFF));
      send_beat(msg_beat(32'h0000_0000, 64'sd0, 31'h7FFF_FFFF));
      send_beat(msg_beat(32'h0000_0000, 64'sd0, 31'h7FFF_FFFF));
      send_beat(msg_beat(32'hFFFF_FFFF, 64'sd3, 31'd100));
      // interval 10: gap 11 passes, 10 is held, 11 passes again
      send_beat(msg_beat(32'h0000_1234, 64'sd11, 31'd7));
      send_beat(msg_beat(32'h0000_1234, 64'sd21, 31'd7));
      send_beat(msg_beat(32'h0000_1234, 64'sd22, 31'd7));
      // time going backwards, then the signed extremes
      send_beat(msg_beat(32'h0000_1234, -64'sd5, 31'd7));
      send_beat(msg_beat(32'h0000_1234, 64'sh7FFF_FFFF_FFFF_FFFF, 31'd7));
      send_beat(msg_beat(32'h0000_1234, 64'sh8000_0000_0000_0000, 31'd7));
      // spare mode with interval 0: equal time held, one later passes
      send_beat(msg_beat(32'h5555_5555, 64'sd0, 31'd1));
      send_beat(msg_beat(32'h5555_5555, 64'sd1, 31'd1));
      // widest interval: gap equal to it held, one more passes
      send_beat(msg_beat(32'hA5A5_A5A5, 64'sh0000_0000_FFFF_FFFF, 31'd2));
      send_beat(msg_beat(32'hA5A5_A5A5, 64'sh0000_0001_0000_0000, 31'd2));
      // reload clears the counters
      send_beat(load_beat(4'd0, 32'h0000_0000, MODE_ALWAYS, 32'd0, 1'b0));
      send_beat(msg_beat(32'h0000_0000, 64'sd9, 31'd5));
      send_beat(msg_beat(32'hDEAD_BEEF, 64'sd9, 31'd5));

      // ---- random part: busy sender, then busy receiver, then no idling ----
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // receiver holds off while the sender keeps offering
            if (phase == 2 && n == 100)
               hold_go = 1'b1;

            // mostly pool keys so the table hits; the rest likely miss
            key = ($urandom_range(99) < 90) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                            : $urandom;
            pick = $urandom_range(99);
            if (pick < 4)
               bytes = 31'h7FFF_FFFF;
            else if (pick < 14)
               bytes = BYTES_W'($urandom);
            else
               bytes = $urandom_range(2000);

            if ($urandom_range(99) < 10) begin
               pick = $urandom_range(99);
               if (pick < 10)
                  ivl = '0;
               else if (pick < 18)
                  ivl = 32'hFFFF_FFFF;
               else if (pick < 28)
                  ivl = $urandom;
               else
                  ivl = $urandom_range(40);
               send_beat(load_beat(SLOT_W'($urandom), key, MODE_W'($urandom), ivl,
                                   $urandom_range(1)));
            end else begin
               // clock mostly creeps forward, with odd jumps back and anywhere
               pick = $urandom_range(99);
               if (pick < 4)
                  now_us = {$urandom, $urandom};
               else if (pick < 9)
                  now_us = now_us - $urandom_range(1, 200);
               else
                  now_us = now_us + $urandom_range(30);
               send_beat(msg_beat(key, now_us, bytes));
            end
         end
      end
      req_valid <= 1'b0;

      // let every outstanding result come home, then a short quiet stretch
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d slot loads and %0d messages under three idling mixes",
               loads_seen, forwards_seen + holds_seen + misses_seen);
      $display("and a long hold-off; messages: %0d forwarded, %0d held, %0d unmatched",
               forwards_seen, holds_seen, misses_seen);
      if (fail_count == 0)
         $display("channel_rate_gate verification clean");
      else
         $display("channel_rate_gate verification failed");
      $finish;
   end

endmodule
